// File: rtl/isort_pkg.sv
// Package for the insertion sorter: item types, cell control struct and defaults.
// No dependencies; used by isort_cell and insertion_sorter.
`default_nettype none

package isort_pkg;

  // Default number of cells in the chain
  localparam int CAPACITY_DEF = 64;

  // Input item
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               overflow;
  } out_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast value
    logic shift;  // move contents one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/isort_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on isort_pkg (cell_ctrl_t).
`default_nettype none

module isort_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire isort_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0]   new_value,
  // neighbor toward the head (lower index)
  input  wire logic signed [31:0]   left_value,
  input  wire logic                 left_valid,
  input  wire logic                 left_gt,
  // neighbor toward the tail (higher index)
  input  wire logic signed [31:0]   right_value,
  input  wire logic                 right_valid,
  output logic signed [31:0]        value_r,
  output logic                      valid_r,
  output logic                      gt
);

  logic signed [31:0] value_nxt;
  logic               valid_nxt;

  // An empty cell counts as greater than anything
  assign gt = !valid_r || (value_r > new_value);

  // Insert: a greater cell takes its left neighbor, or the new value at the boundary
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.ins && gt) begin
      if (left_gt) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/insertion_sorter.sv
// Top level of the insertion sorter: a chain of CAPACITY cells plus drain control.
// Depends on isort_pkg and isort_cell.
`default_nettype none

// The sorter takes one value per cycle (start high, busy low) and keeps the set
// sorted in a chain of CAPACITY cells, every cell comparing against the new
// value at once. Equal values keep arrival order. Values arriving while the
// chain is full are dropped and overflow is reported on every result of that
// set. Accepting the item with last set raises busy on the next cycle; the n
// stored values then stream out of the head cell, one per cycle on out_strobe,
// ascending; out_strobe is a registered copy of busy.
// The receiver cannot stall: each result is shown for exactly one cycle. busy
// falls in the cycle that shows the final result, so a new set may start then.
// No clearing is needed after reset.
module insertion_sorter #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire isort_pkg::in_t  in_data,
  output logic                 out_strobe,
  output isort_pkg::out_t      out_data
);

  logic signed [31:0]    cell_value [CAPACITY];
  logic                  cell_valid [CAPACITY];
  logic                  cell_gt    [CAPACITY];
  isort_pkg::cell_ctrl_t ctrl;

  logic            accept;
  logic            full;
  logic            draining_r, draining_nxt;
  logic            dropped_r,  dropped_nxt;
  logic            out_strobe_r;
  isort_pkg::out_t out_data_r;

  assign accept = start && !draining_r;
  assign full   = cell_valid[CAPACITY-1];
  assign busy   = draining_r;

  // Broadcast command: insert on accepted item with room, shift while draining
  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = draining_r;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] l_value, r_value;
    logic               l_valid, l_gt, r_valid;
    if (i == 0) begin : g_head
      assign l_value = '0;
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
    end else begin : g_mid
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end
    isort_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_value   (in_data.value),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_value (r_value),
      .right_valid (r_valid),
      .value_r     (cell_value[i]),
      .valid_r     (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // Drain control and overflow tracking
  always_comb begin
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    if (draining_r) begin
      // final result leaves when the cell behind the head is empty
      if (!cell_valid[1]) begin
        draining_nxt = 1'b0;
        dropped_nxt  = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_data.last) begin
        draining_nxt = 1'b1;
      end
    end
  end

  // State and registered result
  always_ff @(posedge clk) begin
    out_data_r.sorted_value <= cell_value[0];
    out_data_r.final_res    <= !cell_valid[1];
    out_data_r.overflow     <= dropped_r;
    if (!rst_n) begin
      draining_r   <= 1'b0;
      dropped_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      draining_r   <= draining_nxt;
      dropped_r    <= dropped_nxt;
      out_strobe_r <= draining_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Assertions
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.final_res) |-> !busy)
    else $error("busy still high with final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.final_res) |-> busy)
    else $error("non-final result outside a drain");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last) |=> busy)
    else $error("last item did not start the drain");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cell_valid[0])
    else $error("drain with empty head cell");

endmodule

`default_nettype wire

// File: tb/insertion_sorter_checker.sv
// Checker for the insertion sorter: watches the item and result channels, keeps its
// own sorted set, and compares every result. Depends on isort_pkg.
`default_nettype none

module insertion_sorter_checker #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire isort_pkg::in_t  in_data,
  input  wire logic            out_strobe,
  input  wire isort_pkg::out_t out_data,
  output int                   fail_count,
  output int                   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Shadow of the sorter's set: ascending values, fill level, dropped flag
  logic signed [31:0] set_values [CAPACITY];
  int                 set_count = 0;
  logic               set_dropped = 1'b0;

  // Sorted runs waiting to come out, oldest first
  isort_pkg::out_t    sorted_run_q [$];
  int                 mismatches = 0;

  // Insert after every stored value not greater than v; full set drops v
  task automatic insert_value(input logic signed [31:0] v);
    int pos;
    if (set_count >= CAPACITY) begin
      set_dropped = 1'b1;
      return;
    end
    pos = set_count;
    while (pos > 0 && set_values[pos-1] > v) begin
      set_values[pos] = set_values[pos-1];
      pos--;
    end
    set_values[pos] = v;
    set_count++;
  endtask

  // Closing item: the whole set comes out ascending, then the set starts over
  task automatic queue_sorted_run();
    isort_pkg::out_t r;
    for (int k = 0; k < set_count; k++) begin
      r.sorted_value = set_values[k];
      r.final_res    = (k == set_count - 1);
      r.overflow     = set_dropped;
      sorted_run_q.push_back(r);
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endtask

  task automatic check_result(input isort_pkg::out_t got);
    isort_pkg::out_t want;
    if (sorted_run_q.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: result with nothing expected: value %0d final %0b overflow %0b",
                 $realtime, got.sorted_value, got.final_res, got.overflow);
      mismatches++;
      return;
    end
    want = sorted_run_q.pop_front();
    if (got.sorted_value !== want.sorted_value || got.final_res !== want.final_res ||
        got.overflow !== want.overflow) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: mismatch: expected value %0d final %0b overflow %0b, got %0d %0b %0b",
                 $realtime, want.sorted_value, want.final_res, want.overflow,
                 got.sorted_value, got.final_res, got.overflow);
      mismatches++;
    end
  endtask

  // Results are checked before the item of the same edge is taken in
  always @(posedge clk) begin
    if (!rst_n) begin
      set_count   = 0;
      set_dropped = 1'b0;
      sorted_run_q.delete();
    end else begin
      if (out_strobe)
        check_result(out_data);
      if (start && !busy) begin
        insert_value(in_data.value);
        if (in_data.last)
          queue_sorted_run();
      end
    end
    fail_count      <= mismatches;
    pending_results <= sorted_run_q.size();
  end

endmodule

`default_nettype wire

// File: tb/insertion_sorter_test.sv
// Top of the insertion sorter testbench: clock, reset, directed and random sets of
// items, verdict. Depends on isort_pkg, insertion_sorter and insertion_sorter_checker.
`default_nettype none

module insertion_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 CAP          = isort_pkg::CAPACITY_DEF;
  localparam int                 RANDOM_ITEMS = 360;
  localparam int                 CALM_TAIL    = 60;
  localparam int                 CYCLE_LIMIT  = 200_000;
  localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX      = 32'sh7FFF_FFFF;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  isort_pkg::in_t  in_data;
  logic            out_strobe;
  isort_pkg::out_t out_data;
  int              fail_count;
  int              pending_results;
  int              cycle_count = 0;
  int              random_items = 0;
  logic signed [31:0] recent_value = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  insertion_sorter #(.CAPACITY(CAP)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  insertion_sorter_checker #(.CAPACITY(CAP)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_strobe      (out_strobe),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one item and hold it until the sorter takes it
  task automatic send_item(input logic signed [31:0] v, input logic is_last);
    start   <= 1'b1;
    in_data <= '{value: v, last: is_last};
    do @(posedge clk); while (busy);
    recent_value = v;
  endtask

  // Sender gap; the data lines carry junk meanwhile
  task automatic pause_sender(input int cycles);
    start   <= 1'b0;
    in_data <= '{value: $urandom, last: 1'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // Half full-range values, the rest small ones, near-extremes and repeats
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6:          return $signed($urandom_range(0, 16)) - 8;
      7:             return VAL_MIN + $urandom_range(0, 3);
      8:             return VAL_MAX - $urandom_range(0, 3);
      default:       return recent_value;
    endcase
  endfunction

  // Mostly short sets; a few come near or up to the store size, or run past it
  function automatic int pick_set_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return $urandom_range(1, 6);
    if (sel < 17) return $urandom_range(7, 32);
    if (sel < 19) return $urandom_range(CAP - 2, CAP);
    return $urandom_range(CAP + 1, CAP + 5);
  endfunction

  task automatic send_set(input int n, input bit gappy);
    for (int k = 0; k < n; k++) begin
      if (gappy && $urandom_range(0, 2) == 0)
        pause_sender($urandom_range(1, 11));
      send_item(pick_value(), k == n - 1);
      random_items++;
    end
  endtask

  initial begin
    start   <= 1'b0;
    in_data <= '0;
    rst_n   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-item sets at both extremes
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    // Extremes, zero and equal values in one set
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b1);
    // Descending arrival: every entry moves on each insert
    send_item(4, 1'b0);
    send_item(3, 1'b0);
    send_item(2, 1'b0);
    send_item(1, 1'b0);
    send_item(0, 1'b1);
    // All equal, then alternating bit patterns
    send_item(7, 1'b0);
    send_item(7, 1'b0);
    send_item(7, 1'b1);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shAAAA_AAAA, 1'b1);

    // Overflowing set (closing item dropped), then an exactly full one
    send_set(CAP + 2, 1'b1);
    send_set(CAP, 1'b0);
    while (random_items < RANDOM_ITEMS)
      send_set(pick_set_size(),
               random_items < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 1) == 1);
    start <= 1'b0;

    // Drain, then watch a while longer for stray results
    @(posedge clk);
    while (pending_results != 0)
      @(posedge clk);
    repeat (CAP + 8) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/insertion_sorter.sv
tb/insertion_sorter_checker.sv
tb/insertion_sorter_test.sv
